>>> rtl/core/mpbft_pkg.sv
package mpbft_pkg;

    localparam int unsigned ID_BASE = 100;

    typedef enum logic [2:0] {
        OP_CREATE = 3'd0,
        OP_OPEN   = 3'd1,
        OP_CLOSE  = 3'd2,
        OP_WRITE  = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NEW     = 2'd1,
        ST_BLOCK   = 2'd2,
        ST_REFUSED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  slot;
        logic [31:0] pipe_id;
        logic        reader_end;
        logic [7:0]  write_byte;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  pipe_slot;
        logic [31:0] assigned_id;
        logic [7:0]  read_byte;
        logic        wake_waiter;
        logic        slot_freed;
    } t_rsp;

endpackage

>>> rtl/core/mpbft_if.sv
interface mpbft_req_if;
    logic             valid;
    logic             ready;
    mpbft_pkg::t_req  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mpbft_rsp_if;
    logic             valid;
    logic             ready;
    mpbft_pkg::t_rsp  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/mpbft_ram.sv
module mpbft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

>>> rtl/core/mpbft_ctrl.sv
module mpbft_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mpbft_pkg::t_cmd   o_cmd
);
    mpbft_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpbft_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            mpbft_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = mpbft_pkg::S_EXEC;
                end
            end
            mpbft_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = mpbft_pkg::S_OUT;
            end
            mpbft_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.emit = 1'b1;
                if (i_out_ready) begin
                    n_state = mpbft_pkg::S_IDLE;
                end
            end
            default: n_state = mpbft_pkg::S_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and valid together");
    a_exec_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_out_valid) else $error("exec not followed by result");
    a_latch_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.latch |=> o_cmd.exec) else $error("latch not followed by exec");
`endif
endmodule

>>> rtl/core/mpbft_dp.sv
module mpbft_dp #(
    parameter int SLOTS      = 16,
    parameter int FIFO_DEPTH = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mpbft_pkg::t_cmd  i_cmd,
    input  mpbft_pkg::t_req  i_req,
    output mpbft_pkg::t_rsp  o_rsp
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = PW + 1;
    localparam int AW = $clog2(SLOTS * FIFO_DEPTH);

    mpbft_pkg::t_req r_req;
    logic [SLOTS-1:0] r_valid, r_rd_open, r_wr_open, r_wait;
    logic [31:0]      r_id [SLOTS];
    logic [CW-1:0]    r_fill [SLOTS];
    logic [PW-1:0]    r_rp [SLOTS];
    logic [PW-1:0]    r_wp [SLOTS];
    logic [31:0]      r_ctr;
    mpbft_pkg::t_rsp  r_rsp, n_rsp;

    logic             live, has_free, found_hit, full, empty;
    logic [SW-1:0]    k, free_k, found_k;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [7:0]       ram_rdata;

    assign k    = r_req.slot[SW-1:0];
    assign live = ({28'd0, r_req.slot} < 32'(SLOTS)) && r_valid[k];
    assign full  = r_fill[k] >= CW'(FIFO_DEPTH);
    assign empty = r_fill[k] == '0;

    always_comb begin
        has_free  = 1'b0;
        free_k    = '0;
        found_hit = 1'b0;
        found_k   = '0;
        for (int j = SLOTS - 1; j >= 0; j--) begin
            if (!r_valid[j]) begin
                has_free = 1'b1;
                free_k   = SW'(j);
            end
            if (r_valid[j] && r_id[j] == r_req.pipe_id) begin
                found_hit = 1'b1;
                found_k   = SW'(j);
            end
        end
    end

    assign ram_raddr = {k, r_rp[k]};
    assign ram_waddr = {k, r_wp[k]};
    assign ram_we = i_cmd.exec && r_req.operation == mpbft_pkg::OP_WRITE && live
                    && !r_req.reader_end && !full;

    mpbft_ram #(.WIDTH(8), .DEPTH(SLOTS * FIFO_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_req.write_byte),
        .i_re    (i_cmd.exec),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            r_rsp <= n_rsp;
        end
    end

    always_comb begin
        n_rsp = '0;
        n_rsp.status = mpbft_pkg::ST_REFUSED;
        case (r_req.operation)
            mpbft_pkg::OP_CREATE: begin
                if (has_free) begin
                    n_rsp.status      = mpbft_pkg::ST_DONE;
                    n_rsp.pipe_slot   = 4'(free_k);
                    n_rsp.assigned_id = r_ctr + 32'(mpbft_pkg::ID_BASE);
                end
            end
            mpbft_pkg::OP_OPEN: begin
                if (r_req.pipe_id >= 32'(mpbft_pkg::ID_BASE)) begin
                    if (!found_hit) begin
                        if (has_free) begin
                            n_rsp.status      = mpbft_pkg::ST_NEW;
                            n_rsp.pipe_slot   = 4'(free_k);
                            n_rsp.assigned_id = r_req.pipe_id;
                        end
                    end else if (!(r_req.reader_end ? r_rd_open[found_k]
                                                    : r_wr_open[found_k])) begin
                        n_rsp.status      = mpbft_pkg::ST_DONE;
                        n_rsp.pipe_slot   = 4'(found_k);
                        n_rsp.assigned_id = r_req.pipe_id;
                    end
                end
            end
            mpbft_pkg::OP_CLOSE: begin
                if (live) begin
                    n_rsp.status = mpbft_pkg::ST_DONE;
                    if (!(r_req.reader_end ? r_wr_open[k] : r_rd_open[k])) begin
                        n_rsp.slot_freed = 1'b1;
                    end else begin
                        n_rsp.wake_waiter = r_wait[k];
                    end
                end
            end
            mpbft_pkg::OP_WRITE: begin
                if (live && !r_req.reader_end) begin
                    if (full && r_rd_open[k]) begin
                        n_rsp.status = mpbft_pkg::ST_BLOCK;
                    end else if (!full) begin
                        n_rsp.status      = mpbft_pkg::ST_DONE;
                        n_rsp.wake_waiter = r_wait[k];
                    end
                end
            end
            mpbft_pkg::OP_READ: begin
                if (live && r_req.reader_end) begin
                    if (empty) begin
                        n_rsp.status = mpbft_pkg::ST_BLOCK;
                    end else begin
                        n_rsp.status      = mpbft_pkg::ST_DONE;
                        n_rsp.wake_waiter = r_wait[k];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_open <= '0;
            r_wr_open <= '0;
            r_wait    <= '0;
            r_ctr     <= '0;
            for (int j = 0; j < SLOTS; j++) begin
                r_fill[j] <= '0;
                r_rp[j]   <= '0;
                r_wp[j]   <= '0;
            end
        end else if (i_cmd.exec) begin
            case (r_req.operation)
                mpbft_pkg::OP_CREATE: begin
                    if (has_free) begin
                        r_ctr             <= r_ctr + 32'd1;
                        r_valid[free_k]   <= 1'b1;
                        r_id[free_k]      <= r_ctr + 32'(mpbft_pkg::ID_BASE);
                        r_rd_open[free_k] <= 1'b1;
                        r_wr_open[free_k] <= 1'b1;
                        r_fill[free_k]    <= '0;
                        r_rp[free_k]      <= '0;
                        r_wp[free_k]      <= '0;
                        r_wait[free_k]    <= 1'b0;
                    end
                end
                mpbft_pkg::OP_OPEN: begin
                    if (r_req.pipe_id >= 32'(mpbft_pkg::ID_BASE)) begin
                        if (!found_hit) begin
                            if (has_free) begin
                                r_valid[free_k]   <= 1'b1;
                                r_id[free_k]      <= r_req.pipe_id;
                                r_rd_open[free_k] <= r_req.reader_end;
                                r_wr_open[free_k] <= !r_req.reader_end;
                                r_fill[free_k]    <= '0;
                                r_rp[free_k]      <= '0;
                                r_wp[free_k]      <= '0;
                                r_wait[free_k]    <= 1'b0;
                            end
                        end else if (r_req.reader_end) begin
                            r_rd_open[found_k] <= 1'b1;
                        end else begin
                            r_wr_open[found_k] <= 1'b1;
                        end
                    end
                end
                mpbft_pkg::OP_CLOSE: begin
                    if (live) begin
                        if (r_req.reader_end) begin
                            r_rd_open[k] <= 1'b0;
                        end else begin
                            r_wr_open[k] <= 1'b0;
                        end
                        if (!(r_req.reader_end ? r_wr_open[k] : r_rd_open[k])) begin
                            r_valid[k] <= 1'b0;
                        end
                        r_wait[k] <= 1'b0;
                    end
                end
                mpbft_pkg::OP_WRITE: begin
                    if (live && !r_req.reader_end) begin
                        if (full) begin
                            if (r_rd_open[k]) begin
                                r_wait[k] <= 1'b1;
                            end
                        end else begin
                            r_wp[k]   <= r_wp[k] + PW'(1);
                            r_fill[k] <= r_fill[k] + CW'(1);
                            r_wait[k] <= 1'b0;
                        end
                    end
                end
                mpbft_pkg::OP_READ: begin
                    if (live && r_req.reader_end) begin
                        if (empty) begin
                            r_wait[k] <= 1'b1;
                        end else begin
                            r_rp[k]   <= r_rp[k] + PW'(1);
                            r_fill[k] <= r_fill[k] - CW'(1);
                            r_wait[k] <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_rsp = r_rsp;
        if (r_req.operation == mpbft_pkg::OP_READ
            && r_rsp.status == mpbft_pkg::ST_DONE) begin
            o_rsp.read_byte = ram_rdata;
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> r_fill[k] <= CW'(FIFO_DEPTH)) else $error("fill count beyond depth");
    a_freed_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && n_rsp.slot_freed |=> !r_valid[k]) else $error("freed slot still valid");
    a_wake_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> !(n_rsp.wake_waiter && n_rsp.slot_freed)) else $error("wake and free");
`endif
endmodule

>>> rtl/core/multi_pipe_byte_fifo_table_core.sv
// channel  dir  payload
// i_req    in   operation, slot, pipe_id, reader_end, write_byte
// o_rsp    out  status, pipe_slot, assigned_id, read_byte, wake_waiter, slot_freed
// An item passes through accept, execute (metadata update, buffer RAM access)
// and result register. The RAM read data returns in the result cycle.
// Reset clears all slot marks, counts, pointers and the id counter.
// A stalled result holds the block; the next item is taken once it leaves.
module multi_pipe_byte_fifo_table_core #(
    parameter int SLOTS      = 16,
    parameter int FIFO_DEPTH = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpbft_req_if.sink   i_req,
    mpbft_rsp_if.source o_rsp
);
    mpbft_pkg::t_cmd cmd;

    mpbft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    mpbft_dp #(.SLOTS(SLOTS), .FIFO_DEPTH(FIFO_DEPTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req.payload),
        .o_rsp   (o_rsp.payload)
    );
endmodule
